// ----- sv/sha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Word types, initial hash values and the round constant table.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;
  typedef logic [511:0] block_t;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned RndW = $clog2(RoundCount);

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadMarker = 8'h80;

  function automatic word_t round_k(input logic [RndW-1:0] r);
    word_t k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/sha_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round on the working variables and the next schedule word.
// ----------------------------------------------------------------------------
module sha_round import sha_pkg::*; (
  input  hash_t  vars_i,
  input  block_t msg_i,
  input  word_t  k_i,
  output hash_t  vars_o,
  output word_t  w_new_o
);

  word_t w0, w1, w9, w14;
  word_t s0, s1, big_s0, big_s1, ch, maj, t1, t2;

  // Word 0 of the schedule window sits in the top 32 bits.
  assign w0  = msg_i[511:480];
  assign w1  = msg_i[479:448];
  assign w9  = msg_i[223:192];
  assign w14 = msg_i[63:32];

  assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
  assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]}
            ^ {10'b0, w14[31:10]};
  assign w_new_o = w0 + s0 + w9 + s1;

  assign big_s1 = {vars_i[4][5:0], vars_i[4][31:6]} ^ {vars_i[4][10:0], vars_i[4][31:11]}
                ^ {vars_i[4][24:0], vars_i[4][31:25]};
  assign ch     = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign big_s0 = {vars_i[0][1:0], vars_i[0][31:2]} ^ {vars_i[0][12:0], vars_i[0][31:13]}
                ^ {vars_i[0][21:0], vars_i[0][31:22]};
  assign maj    = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2])
                ^ (vars_i[1] & vars_i[2]);
  assign t1     = vars_i[7] + big_s1 + ch + k_i + w0;
  assign t2     = big_s0 + maj;

  assign vars_o[7] = vars_i[6];
  assign vars_o[6] = vars_i[5];
  assign vars_o[5] = vars_i[4];
  assign vars_o[4] = vars_i[3] + t1;
  assign vars_o[3] = vars_i[2];
  assign vars_o[2] = vars_i[1];
  assign vars_o[1] = vars_i[0];
  assign vars_o[0] = t1 + t2;

endmodule

// ----- sv/sha256_hasher.sv -----
`timescale 1ns / 1ps
// Message bytes are taken one per cycle while in_ready is high; a filled 64-byte
// block then runs 64 rounds of the shared round unit and folds into the hash.
// At the end of a message padding runs one byte per cycle between up to two
// compressions; the eight digest words leave one per cycle while out_ready holds.
// Synchronous active-low reset loads the initial hash and clears all counters.
// ----------------------------------------------------------------------------
// SHA-256 streaming hasher
// Byte-wide message input, block padding and eight-word digest output.
// ----------------------------------------------------------------------------
module sha256_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PADM  = 3'd3;
  localparam logic [2:0] S_PADZ  = 3'd4;
  localparam logic [2:0] S_PADL  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  logic [2:0]      state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]      pos_r, pos_nxt;
  logic [63:0]     bitlen_r, bitlen_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [2:0]      oidx_r, oidx_nxt;
  hash_t           chain_r, chain_nxt, vars_r, vars_nxt, round_vars;
  block_t          msg_r, msg_nxt;
  word_t           w_new;
  logic            push_en;
  logic [7:0]      push_byte;

  sha_round u_round (
    .vars_i  (vars_r),
    .msg_i   (msg_r),
    .k_i     (round_k(rnd_r)),
    .vars_o  (round_vars),
    .w_new_o (w_new)
  );

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    pos_nxt    = pos_r;
    bitlen_nxt = bitlen_r;
    rnd_nxt    = rnd_r;
    oidx_nxt   = oidx_r;
    chain_nxt  = chain_r;
    vars_nxt   = vars_r;
    msg_nxt    = msg_r;
    push_en    = 1'b0;
    push_byte  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_byte_present) begin
            push_en    = 1'b1;
            push_byte  = in_data_byte;
            bitlen_nxt = bitlen_r + 64'd8;
          end
          ret_nxt   = in_is_last ? S_PADM : S_IDLE;
          state_nxt = in_is_last ? S_PADM : S_IDLE;
        end
      end
      S_ROUND: begin
        vars_nxt = round_vars;
        msg_nxt  = {msg_r[479:0], w_new};
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == RndW'(RoundCount - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        state_nxt = ret_r;
      end
      S_PADM: begin
        push_en   = 1'b1;
        push_byte = PadMarker;
        ret_nxt   = S_PADZ;
        state_nxt = S_PADZ;
      end
      S_PADZ: begin
        if (pos_r == LenPos) begin
          state_nxt = S_PADL;
        end else begin
          push_en = 1'b1;
          ret_nxt = S_PADZ;
        end
      end
      S_PADL: begin
        push_en    = 1'b1;
        push_byte  = bitlen_r[63:56];
        bitlen_nxt = {bitlen_r[55:0], bitlen_r[63:56]};
        ret_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 1'b1;
          if (oidx_r == 3'd7) begin
            chain_nxt  = InitHash;
            bitlen_nxt = '0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push_en) begin
      msg_nxt = {msg_r[503:0], push_byte};
      pos_nxt = pos_r + 1'b1;
      if (pos_r == LastPos) begin
        state_nxt = S_ROUND;
        vars_nxt  = chain_r;
        rnd_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      pos_r    <= '0;
      bitlen_r <= '0;
      rnd_r    <= '0;
      oidx_r   <= '0;
      chain_r  <= InitHash;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      pos_r    <= pos_nxt;
      bitlen_r <= bitlen_nxt;
      rnd_r    <= rnd_nxt;
      oidx_r   <= oidx_nxt;
      chain_r  <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
    msg_r  <= msg_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = chain_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

endmodule

// ----- sv/sha_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Checks digest sequencing and the input/output handshake at the ports.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // A digest is never offered while a new item can be taken.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("digest offered while input is ready");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last flag does not match word index");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words out of order");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input ready straight after the end of a message");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word))
    else $error("stalled digest word changed");

endmodule

bind sha256_hasher sha_checker u_sha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_is_last      (in_is_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);
